@@ rtl/kat_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kat_pkg: shared types and constants of the key auto-repeat tracker
// Holds the slot phase and controller state encodings, the configuration
// register indexes, reset values and the control bundle driven into the cells.
// ---------------------------------------------------------------------------
package kat_pkg;

    localparam int KEY_W         = 8;
    localparam int NUM_KEYS      = 6;
    localparam int CNT_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int MS_W          = 16;
    localparam int NOW_W         = 32;
    localparam int DEF_SLOTS     = 6;
    localparam int DEF_TIME_BITS = 32;

    localparam logic [MS_W-1:0]  HOLD_MS_RST   = 16'd100;
    localparam logic [MS_W-1:0]  REPEAT_MS_RST = 16'd60;
    localparam logic [KEY_W-1:0] ESC_CODE_RST  = 8'd27;
    localparam logic [KEY_W-1:0] SEL_CODE_RST  = 8'd0;
    localparam logic [KEY_W-1:0] HOME_CODE_RST = 8'd0;
    localparam logic [CNT_W-1:0] MAX_COUNT     = 3'd6;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HOLD   = 2'd1,
        PH_REPEAT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MARK = 2'd1,
        ST_WALK = 2'd2
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESC_HOME    = 3'd0,
        CFG_HOLD_MS     = 3'd1,
        CFG_REPEAT_MS   = 3'd2,
        CFG_ESC_CODE    = 3'd3,
        CFG_SELECT_CODE = 3'd4,
        CFG_HOME_CODE   = 3'd5
    } cfg_reg_t;

    // Control bundle broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic             mark_en;
        logic             shift_en;
        logic             any_hit;
        logic [KEY_W-1:0] code;
    } cell_ctl_t;

endpackage

@@ rtl/key_autorepeat_tracker_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_autorepeat_tracker_unit: keyboard typematic auto-repeat tracker
// Turns keyboard poll reports into press and release events with hold and
// repeat timing, using a rotating chain of key slot cells.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one poll report per transfer: six key codes, a count
//   and the millisecond time. s_ready is high only while no report is being
//   worked on. The m_ channel returns zero to SLOTS events per report, in
//   slot order, with m_last_event set on the final one.
//   Between its transfer and the taking of the next report, each reported
//   key (at most six) in turn matches or claims a slot, then the slot chain
//   rotates once, slot by slot, past the head cell that is evaluated.
//   Each event is loaded into the output register from the head cell
//   while its slot is at the head. A stalled receiver holds the rotation
//   whenever the head slot has an event and the output register is still
//   occupied.
//   The cfg_ write channel is always ready; writes belong in idle periods.
//   Synchronous reset frees all slots and restores the register defaults.
// ---------------------------------------------------------------------------
module key_autorepeat_tracker_unit
    import kat_pkg::*;
#(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KEY_W-1:0]      s_key_a,
    input  logic [KEY_W-1:0]      s_key_b,
    input  logic [KEY_W-1:0]      s_key_c,
    input  logic [KEY_W-1:0]      s_key_d,
    input  logic [KEY_W-1:0]      s_key_e,
    input  logic [KEY_W-1:0]      s_key_f,
    input  logic [CNT_W-1:0]      s_key_count,
    input  logic [NOW_W-1:0]      s_now_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KEY_W-1:0]      m_event_key,
    output logic                  m_event_release,
    output logic                  m_last_event,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Configuration registers.
    logic             esc_home_reg;
    logic [MS_W-1:0]  hold_ms_reg;
    logic [MS_W-1:0]  repeat_ms_reg;
    logic [KEY_W-1:0] esc_code_reg;
    logic [KEY_W-1:0] select_code_reg;
    logic [KEY_W-1:0] home_code_reg;

    // Sequencer.
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [KEY_W-1:0]     key_q_reg [NUM_KEYS];
    logic [TIME_BITS-1:0] now_reg;
    logic                 in_xfer;
    logic                 mark_step;
    logic                 walk_adv;
    logic                 out_load;
    logic                 out_free;
    logic                 later_emit;
    logic [CNT_W-1:0]     count_sat;
    cell_ctl_t            ctl;

    // Output register.
    logic             m_valid_reg;
    logic [KEY_W-1:0] m_key_reg;
    logic             m_release_reg;
    logic             m_last_reg;
    logic [KEY_W-1:0] head_code;

    // Cell chain wiring.
    logic [KEY_W-1:0]     key_w       [SLOTS];
    phase_t               phase_w     [SLOTS];
    logic [SLOTS-1:0]     seen_w;
    logic [TIME_BITS-1:0] stamp_w     [SLOTS];
    logic [KEY_W-1:0]     upd_key_w   [SLOTS];
    phase_t               upd_phase_w [SLOTS];
    logic [SLOTS-1:0]     upd_seen_w;
    logic [TIME_BITS-1:0] upd_stamp_w [SLOTS];
    logic [SLOTS-1:0]     emit_w;
    logic [SLOTS-1:0]     rel_w;
    logic [SLOTS-1:0]     hit_w;
    logic [SLOTS:0]       free_chain;

    assign free_chain[0] = 1'b0;

    assign ctl.code     = key_q_reg[0];
    assign ctl.mark_en  = mark_step && (key_q_reg[0] != '0);
    assign ctl.any_hit  = |hit_w;
    assign ctl.shift_en = walk_adv;

    // The chain rotates toward the head; the head's updated slot wraps to the tail.
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic [KEY_W-1:0]     sh_key;
        phase_t               sh_phase;
        logic                 sh_seen;
        logic [TIME_BITS-1:0] sh_stamp;

        if (i == SLOTS - 1) begin : g_tail
            assign sh_key   = upd_key_w[0];
            assign sh_phase = upd_phase_w[0];
            assign sh_seen  = upd_seen_w[0];
            assign sh_stamp = upd_stamp_w[0];
        end else begin : g_body
            assign sh_key   = key_w[i+1];
            assign sh_phase = phase_w[i+1];
            assign sh_seen  = seen_w[i+1];
            assign sh_stamp = stamp_w[i+1];
        end

        kat_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .hold_ms    (hold_ms_reg),
            .repeat_ms  (repeat_ms_reg),
            .now        (now_reg),
            .free_in    (free_chain[i]),
            .free_out   (free_chain[i+1]),
            .hit        (hit_w[i]),
            .shift_key  (sh_key),
            .shift_phase(sh_phase),
            .shift_seen (sh_seen),
            .shift_stamp(sh_stamp),
            .key        (key_w[i]),
            .phase      (phase_w[i]),
            .seen       (seen_w[i]),
            .stamp      (stamp_w[i]),
            .upd_key    (upd_key_w[i]),
            .upd_phase  (upd_phase_w[i]),
            .upd_seen   (upd_seen_w[i]),
            .upd_stamp  (upd_stamp_w[i]),
            .emit       (emit_w[i]),
            .ev_release (rel_w[i])
        );
    end

    // Slots not yet visited in this walk sit at positions 1 .. SLOTS-1-step.
    always_comb begin
        later_emit = 1'b0;
        for (int p = 1; p < SLOTS; p++) begin
            if (p + int'(step_reg) < SLOTS) begin
                later_emit = later_emit | emit_w[p];
            end
        end
    end

    assign count_sat = (s_key_count > MAX_COUNT) ? MAX_COUNT : s_key_count;
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = walk_adv && emit_w[0];
    assign head_code = (esc_home_reg && ((key_w[0] == esc_code_reg) ||
                                         (key_w[0] == select_code_reg)))
                       ? home_code_reg : key_w[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mark_step  = 1'b0;
        walk_adv   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = (count_sat == '0) ? ST_WALK : ST_MARK;
                end
            end
            ST_MARK: begin
                mark_step = 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                walk_adv = !emit_w[0] || out_free;
                if (walk_adv && (step_reg == STEP_W'(SLOTS - 1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            step_reg <= '0;
        end else if (in_xfer) begin
            cnt_reg  <= count_sat;
            step_reg <= '0;
        end else begin
            if (mark_step) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (walk_adv) begin
                step_reg <= (step_reg == STEP_W'(SLOTS - 1)) ? '0 : step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            key_q_reg[0] <= s_key_a;
            key_q_reg[1] <= s_key_b;
            key_q_reg[2] <= s_key_c;
            key_q_reg[3] <= s_key_d;
            key_q_reg[4] <= s_key_e;
            key_q_reg[5] <= s_key_f;
            now_reg      <= TIME_BITS'(s_now_ms);
        end else if (mark_step) begin
            for (int k = 0; k < NUM_KEYS - 1; k++) begin
                key_q_reg[k] <= key_q_reg[k+1];
            end
            key_q_reg[NUM_KEYS-1] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_key_reg     <= head_code;
            m_release_reg <= rel_w[0];
            m_last_reg    <= !later_emit;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_key     = m_key_reg;
    assign m_event_release = m_release_reg;
    assign m_last_event    = m_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_home_reg    <= 1'b0;
            hold_ms_reg     <= HOLD_MS_RST;
            repeat_ms_reg   <= REPEAT_MS_RST;
            esc_code_reg    <= ESC_CODE_RST;
            select_code_reg <= SEL_CODE_RST;
            home_code_reg   <= HOME_CODE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ESC_HOME:    esc_home_reg    <= cfg_data[0];
                CFG_HOLD_MS:     hold_ms_reg     <= cfg_data[MS_W-1:0];
                CFG_REPEAT_MS:   repeat_ms_reg   <= cfg_data[MS_W-1:0];
                CFG_ESC_CODE:    esc_code_reg    <= cfg_data[KEY_W-1:0];
                CFG_SELECT_CODE: select_code_reg <= cfg_data[KEY_W-1:0];
                CFG_HOME_CODE:   home_code_reg   <= cfg_data[KEY_W-1:0];
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    logic dup_key;

    always_comb begin
        dup_key = 1'b0;
        for (int a = 0; a < SLOTS; a++) begin
            for (int b = a + 1; b < SLOTS; b++) begin
                if ((key_w[a] != '0) && (key_w[a] == key_w[b])) begin
                    dup_key = 1'b1;
                end
            end
        end
    end

    // A key never occupies two slots.
    a_unique_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        !dup_key)
        else $error("key held in two slots");

    // An event is only loaded when the output register can take it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register overwritten");

    // Every walk leaves all seen flags clear.
    a_seen_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (seen_w == '0))
        else $error("seen flag left set outside a report");

    // A finished walk returns the step counter to the head position.
    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && (state_next == ST_IDLE)) |=> (step_reg == '0))
        else $error("walk ended off the head position");
`endif

endmodule

@@ rtl/kat_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kat_cell: one key slot of the tracker chain
// Holds key, phase, seen flag and timestamp. Marks or claims itself for a
// reported key, computes its own walk update and loads its neighbor's state
// when the chain rotates.
// ---------------------------------------------------------------------------
module kat_cell
    import kat_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctl_t            ctl,
    input  logic [MS_W-1:0]      hold_ms,
    input  logic [MS_W-1:0]      repeat_ms,
    input  logic [TIME_BITS-1:0] now,
    input  logic                 free_in,
    output logic                 free_out,
    output logic                 hit,
    input  logic [KEY_W-1:0]     shift_key,
    input  phase_t               shift_phase,
    input  logic                 shift_seen,
    input  logic [TIME_BITS-1:0] shift_stamp,
    output logic [KEY_W-1:0]     key,
    output phase_t               phase,
    output logic                 seen,
    output logic [TIME_BITS-1:0] stamp,
    output logic [KEY_W-1:0]     upd_key,
    output phase_t               upd_phase,
    output logic                 upd_seen,
    output logic [TIME_BITS-1:0] upd_stamp,
    output logic                 emit,
    output logic                 ev_release
);

    logic [KEY_W-1:0]     key_reg;
    phase_t               phase_reg;
    logic                 seen_reg;
    logic [TIME_BITS-1:0] stamp_reg;
    logic                 occupied;
    logic                 claim;
    logic [TIME_BITS-1:0] elapsed;

    assign occupied = (key_reg != '0);
    assign hit      = occupied && (key_reg == ctl.code);
    assign free_out = free_in || !occupied;
    // Only the first free cell in the chain claims a key that matched nowhere.
    assign claim    = ctl.mark_en && !ctl.any_hit && !occupied && !free_in;
    assign elapsed  = now - stamp_reg;

    always_comb begin
        upd_key    = key_reg;
        upd_phase  = phase_reg;
        upd_seen   = seen_reg;
        upd_stamp  = stamp_reg;
        emit       = 1'b0;
        ev_release = 1'b0;
        if (occupied) begin
            upd_seen = 1'b0;
            if (!seen_reg) begin
                emit       = 1'b1;
                ev_release = 1'b1;
                upd_key    = '0;
                upd_phase  = PH_IDLE;
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        emit      = 1'b1;
                        upd_phase = PH_HOLD;
                        upd_stamp = now;
                    end
                    PH_HOLD: begin
                        if (elapsed > TIME_BITS'(hold_ms)) begin
                            upd_phase = PH_REPEAT;
                            upd_stamp = now;
                        end
                    end
                    PH_REPEAT: begin
                        if (elapsed > TIME_BITS'(repeat_ms)) begin
                            emit      = 1'b1;
                            upd_stamp = now;
                        end
                    end
                    default: begin
                        upd_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            phase_reg <= PH_IDLE;
            seen_reg  <= 1'b0;
            stamp_reg <= '0;
        end else if (ctl.shift_en) begin
            key_reg   <= shift_key;
            phase_reg <= shift_phase;
            seen_reg  <= shift_seen;
            stamp_reg <= shift_stamp;
        end else if (claim) begin
            key_reg   <= ctl.code;
            phase_reg <= PH_IDLE;
            seen_reg  <= 1'b1;
            stamp_reg <= '0;
        end else if (ctl.mark_en && hit) begin
            seen_reg  <= 1'b1;
        end
    end

    assign key   = key_reg;
    assign phase = phase_reg;
    assign seen  = seen_reg;
    assign stamp = stamp_reg;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the key auto-repeat tracker
// Keyboard poll reports go in on the s_ channel and the press and release
// events that come back on the m_ channel are compared, field by field and in
// order, with a slot-level model of the tracker kept inside the bench. The
// run goes through several register settings, a directed opening, typing
// sequences with random content and noise reports, random idling on both
// sides and one long receiver hold-off that backs the tracker up.
// ---------------------------------------------------------------------------
module tb_top
    import kat_pkg::*;
();

    localparam int NUM_SLOTS    = DEF_SLOTS;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF_LEN = 400;

    // Indexes past the register file; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [NUM_KEYS-1:0][KEY_W-1:0] codes;
        logic [CNT_W-1:0]               count;
        logic [NOW_W-1:0]               now_ms;
    } poll_report_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             is_release;
        logic             is_last;
    } key_event_t;

    class typematic_scoreboard;
        logic [KEY_W-1:0] slot_code  [NUM_SLOTS];
        phase_t           slot_phase [NUM_SLOTS];
        logic             slot_seen  [NUM_SLOTS];
        logic [NOW_W-1:0] slot_stamp [NUM_SLOTS];

        logic             remap_en;
        logic [MS_W-1:0]  hold_ms;
        logic [MS_W-1:0]  repeat_ms;
        logic [KEY_W-1:0] esc_key;
        logic [KEY_W-1:0] select_key;
        logic [KEY_W-1:0] home_key;

        key_event_t expected_events[$];
        int         errors;

        function new();
            remap_en   = 1'b0;
            hold_ms    = HOLD_MS_RST;
            repeat_ms  = REPEAT_MS_RST;
            esc_key    = ESC_CODE_RST;
            select_key = SEL_CODE_RST;
            home_key   = HOME_CODE_RST;
            errors     = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_code[i]  = '0;
                slot_phase[i] = PH_IDLE;
                slot_seen[i]  = 1'b0;
                slot_stamp[i] = '0;
            end
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ESC_HOME:    remap_en   = data[0];
                CFG_HOLD_MS:     hold_ms    = data[MS_W-1:0];
                CFG_REPEAT_MS:   repeat_ms  = data[MS_W-1:0];
                CFG_ESC_CODE:    esc_key    = data[KEY_W-1:0];
                CFG_SELECT_CODE: select_key = data[KEY_W-1:0];
                CFG_HOME_CODE:   home_key   = data[KEY_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        // A reported key either refreshes its slot or takes the first free one, if any.
        function void claim_slot(logic [KEY_W-1:0] code);
            if (code == '0)
                return;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_code[i] == code) begin
                    slot_seen[i] = 1'b1;
                    return;
                end
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_code[i] == '0) begin
                    slot_code[i]  = code;
                    slot_phase[i] = PH_IDLE;
                    slot_stamp[i] = '0;
                    slot_seen[i]  = 1'b1;
                    return;
                end
            end
        endfunction

        function logic [KEY_W-1:0] event_code(logic [KEY_W-1:0] code);
            if (remap_en && (code == esc_key || code == select_key))
                return home_key;
            return code;
        endfunction

        function void note_report(poll_report_t r);
            logic [CNT_W-1:0] cnt;
            logic [NOW_W-1:0] elapsed;
            logic [KEY_W-1:0] code;
            logic             emit;
            logic             rel;
            key_event_t       ev;
            key_event_t       batch[$];
            cnt = (r.count > MAX_COUNT) ? MAX_COUNT : r.count;
            for (int i = 0; i < int'(cnt); i++)
                claim_slot(r.codes[i]);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                code = slot_code[i];
                if (code == '0)
                    continue;
                emit = 1'b0;
                rel  = 1'b0;
                if (!slot_seen[i]) begin
                    emit          = 1'b1;
                    rel           = 1'b1;
                    slot_code[i]  = '0;
                    slot_phase[i] = PH_IDLE;
                end else begin
                    elapsed = r.now_ms - slot_stamp[i];
                    case (slot_phase[i])
                        PH_IDLE: begin
                            emit          = 1'b1;
                            slot_phase[i] = PH_HOLD;
                            slot_stamp[i] = r.now_ms;
                        end
                        PH_HOLD: begin
                            if (elapsed > NOW_W'(hold_ms)) begin
                                slot_stamp[i] = r.now_ms;
                                slot_phase[i] = PH_REPEAT;
                            end
                        end
                        PH_REPEAT: begin
                            if (elapsed > NOW_W'(repeat_ms)) begin
                                slot_stamp[i] = r.now_ms;
                                emit          = 1'b1;
                            end
                        end
                        default: slot_phase[i] = PH_IDLE;
                    endcase
                end
                slot_seen[i] = 1'b0;
                if (emit) begin
                    ev.key        = event_code(code);
                    ev.is_release = rel;
                    ev.is_last    = 1'b0;
                    batch.push_back(ev);
                end
            end
            if (batch.size() > 0)
                batch[batch.size()-1].is_last = 1'b1;
            for (int i = 0; i < batch.size(); i++)
                expected_events.push_back(batch[i]);
        endfunction

        function void check_event(logic [KEY_W-1:0] key, logic rel, logic last_ev);
            key_event_t exp_ev;
            if (expected_events.size() == 0) begin
                $display("%0t: event with none expected: key %02h release %0b last %0b",
                         $time, key, rel, last_ev);
                errors++;
                return;
            end
            exp_ev = expected_events.pop_front();
            if (key !== exp_ev.key) begin
                $display("%0t: event_key expected %02h, got %02h", $time, exp_ev.key, key);
                errors++;
            end
            if (rel !== exp_ev.is_release) begin
                $display("%0t: event_release expected %0b, got %0b",
                         $time, exp_ev.is_release, rel);
                errors++;
            end
            if (last_ev !== exp_ev.is_last) begin
                $display("%0t: last_event expected %0b, got %0b", $time, exp_ev.is_last, last_ev);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [KEY_W-1:0]      s_key_a         = '0;
    logic [KEY_W-1:0]      s_key_b         = '0;
    logic [KEY_W-1:0]      s_key_c         = '0;
    logic [KEY_W-1:0]      s_key_d         = '0;
    logic [KEY_W-1:0]      s_key_e         = '0;
    logic [KEY_W-1:0]      s_key_f         = '0;
    logic [CNT_W-1:0]      s_key_count     = '0;
    logic [NOW_W-1:0]      s_now_ms        = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [KEY_W-1:0]      m_event_key;
    logic                  m_event_release;
    logic                  m_last_event;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;

    typematic_scoreboard sb;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    bit                  hold_off_req  = 1'b0;
    logic [NOW_W-1:0]    clock_ms      = '0;
    logic [KEY_W-1:0]    held_keys[$];

    key_autorepeat_tracker_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_a         (s_key_a),
        .s_key_b         (s_key_b),
        .s_key_c         (s_key_c),
        .s_key_d         (s_key_d),
        .s_key_e         (s_key_e),
        .s_key_f         (s_key_f),
        .s_key_count     (s_key_count),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_key     (m_event_key),
        .m_event_release (m_event_release),
        .m_last_event    (m_last_event),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

    // Event receiver: checks each transfer, then picks the next ready value.
    initial begin : event_receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_event(m_event_key, m_event_release, m_last_event);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_LEN;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_report(input poll_report_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_key_a     <= r.codes[0];
        s_key_b     <= r.codes[1];
        s_key_c     <= r.codes[2];
        s_key_d     <= r.codes[3];
        s_key_e     <= r.codes[4];
        s_key_f     <= r.codes[5];
        s_key_count <= r.count;
        s_now_ms    <= r.now_ms;
        do @(posedge aclk); while (!s_ready);
        sb.note_report(r);
    endtask

    task automatic send_keys(input logic [KEY_W-1:0] a, b, c, d, e, f,
                             input logic [CNT_W-1:0] cnt, input logic [NOW_W-1:0] t);
        poll_report_t r;
        r.codes  = {f, e, d, c, b, a};
        r.count  = cnt;
        r.now_ms = t;
        send_report(r);
    endtask

    // Waits until the tracker has delivered everything and gone quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(idx, data);
    endtask

    // Upper data bits of the enable and code writes are random so that the register width masking is exercised.
    task automatic configure(input logic en, input logic [MS_W-1:0] hold, rpt,
                             input logic [KEY_W-1:0] esc, sel, home, input bit spare);
        logic [CFG_DATA_W-1:0] data;
        data    = CFG_DATA_W'($urandom);
        data[0] = en;
        write_reg(CFG_ESC_HOME, data);
        write_reg(CFG_HOLD_MS, hold);
        write_reg(CFG_REPEAT_MS, rpt);
        write_reg(CFG_ESC_CODE, {(CFG_DATA_W-KEY_W)'($urandom), esc});
        write_reg(CFG_SELECT_CODE, {(CFG_DATA_W-KEY_W)'($urandom), sel});
        write_reg(CFG_HOME_CODE, {(CFG_DATA_W-KEY_W)'($urandom), home});
        if (spare) begin
            write_reg(CFG_SPARE_A, '1);
            write_reg(CFG_SPARE_B, '1);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12 && sb.esc_key != '0)
            return sb.esc_key;
        if (r < 20 && sb.select_key != '0)
            return sb.select_key;
        if (r < 25 && sb.home_key != '0)
            return sb.home_key;
        if (r < 85)
            return KEY_W'($urandom_range(4, 11));
        return KEY_W'($urandom_range(1, 255));
    endfunction

    // Steps cluster around the hold and repeat thresholds to hit the strict compare.
    function automatic logic [NOW_W-1:0] next_time(logic [NOW_W-1:0] t);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return t + $urandom_range(0, 20);
        if (r < 55)
            return t + sb.hold_ms + $urandom_range(0, 2) - 1;
        if (r < 75)
            return t + sb.repeat_ms + $urandom_range(0, 2) - 1;
        if (r < 92)
            return t + $urandom_range(0, 3 * sb.hold_ms + 3);
        return NOW_W'($urandom);
    endfunction

    // A plausible keyboard: a set of held keys that grows and shrinks slowly.
    function automatic poll_report_t typing_report(logic [NOW_W-1:0] t);
        poll_report_t     r;
        int               n;
        int               start;
        int               pick;
        bit               found;
        logic [KEY_W-1:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 22 && held_keys.size() < 8) begin
            code  = pick_code();
            found = 1'b0;
            foreach (held_keys[i])
                if (held_keys[i] == code)
                    found = 1'b1;
            if (!found)
                held_keys.push_back(code);
        end else if (pick < 40 && held_keys.size() > 0) begin
            held_keys.delete($urandom_range(0, held_keys.size() - 1));
        end
        for (int j = 0; j < NUM_KEYS; j++)
            r.codes[j] = KEY_W'($urandom);
        n     = (held_keys.size() > NUM_KEYS) ? NUM_KEYS : held_keys.size();
        start = (held_keys.size() > 0) ? $urandom_range(0, held_keys.size() - 1) : 0;
        for (int j = 0; j < n; j++)
            r.codes[j] = held_keys[(start + j) % held_keys.size()];
        // Now and then a zero code or a repeated code sits among the valid ones.
        if (n < NUM_KEYS && $urandom_range(0, 9) == 0) begin
            r.codes[n] = (n > 0 && $urandom_range(0, 1) == 1) ? r.codes[0] : '0;
            n++;
        end
        r.count = CNT_W'(n);
        if (n == NUM_KEYS && $urandom_range(0, 3) == 0)
            r.count = '1;
        r.now_ms = t;
        return r;
    endfunction

    task automatic run_random(input int items);
        poll_report_t r;
        for (int k = 0; k < items; k++) begin
            clock_ms = next_time(clock_ms);
            if ($urandom_range(0, 99) < 85) begin
                r = typing_report(clock_ms);
            end else begin
                for (int j = 0; j < NUM_KEYS; j++)
                    r.codes[j] = KEY_W'($urandom);
                r.count  = CNT_W'($urandom_range(0, 7));
                r.now_ms = clock_ms;
            end
            send_report(r);
        end
    endtask

    initial begin : stimulus
        logic [NOW_W-1:0] t0;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 6;
        recv_idle_pct = 77;

        // Directed opening with the reset settings: hold 100, repeat 60.
        t0 = 32'hFFFF_FF00;
        send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, t0);
        send_keys(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, t0);
        send_keys(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, t0 + 100);
        send_keys(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, t0 + 101);
        send_keys(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, t0 + 161);
        send_keys(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, t0 + 162);
        // Time wraps past zero here; a zero code and a duplicate ride along.
        send_keys(8'h04, 8'h00, 8'h05, 8'h05, 8'hFF, 8'h1B, 3'd6, t0 + 300);
        // Count of seven acts as six; only two free slots remain for six new keys.
        send_keys(8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 3'd7, t0 + 305);
        send_keys(8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 3'd7, t0 + 310);
        send_keys(8'h10, 8'h11, 8'h20, 8'h21, 8'h22, 8'h23, 3'd2, t0 + 320);
        send_keys(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, t0 + 330);
        send_keys(8'h80, 8'h40, 8'h20, 8'h08, 8'h02, 8'h01, 3'd6, 32'h7FFF_FFFF);
        send_keys(8'h80, 8'h40, 8'h20, 8'h08, 8'h02, 8'h01, 3'd6, 32'h8000_0064);
        send_keys(8'h80, 8'h40, 8'h20, 8'h08, 8'h02, 8'h01, 3'd6, 32'h8000_00A1);
        send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 32'h8000_00B0);
        clock_ms = 32'h8000_00B0;
        settle();

        // Remap on, zero hold and repeat: once in repeat, a held key repeats whenever the time moves on.
        configure(1'b1, 16'd0, 16'd0, 8'h01, 8'h80, 8'h00, 1'b0);
        run_random(80);
        settle();

        send_idle_pct = 77;
        recv_idle_pct = 6;
        configure(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFE, 8'hFF, 1'b0);
        run_random(30);
        settle();

        configure(1'($urandom_range(0, 1)), MS_W'($urandom_range(0, 400)),
                  MS_W'($urandom_range(0, 400)), KEY_W'($urandom_range(4, 11)),
                  KEY_W'($urandom_range(0, 255)), KEY_W'($urandom_range(0, 255)), 1'b0);
        run_random(70);
        settle();

        // No idling; the receiver holds off long enough to back the tracker up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(1'b0, HOLD_MS_RST, REPEAT_MS_RST, ESC_CODE_RST, SEL_CODE_RST,
                  HOME_CODE_RST, 1'b1);
        hold_off_req = 1'b1;
        run_random(70);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
